// ===== sv/bqls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_pkg
// Shared types, constants and the hash mixing function of the quadgram scorer.
// ----------------------------------------------------------------------------
package bqls_pkg;

	localparam int TABLE_DEPTH_DEF = 65536;
	localparam int MAX_LABELS_DEF  = 16;
	localparam int GRAM_BYTES      = 4;
	localparam int SCORE_W         = 48;
	localparam int WEIGHT_W        = 16;

	localparam logic [7:0]  PAD_BYTE  = 8'hff;
	localparam logic [31:0] HASH_SEED = 32'd1315423911;

	// apb register word indexes
	localparam logic REG_LABEL_COUNT = 1'b0;
	localparam logic REG_INDEX_MASK  = 1'b1;

	typedef enum logic [1:0] {
		CMD_POINT  = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_START  = 2'd3
	} bqls_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SHIFT,
		ST_HASH,
		ST_LOOKUP,
		ST_DRAIN,
		ST_SCAN,
		ST_SETTLE,
		ST_EMIT
	} bqls_state_t;

	// controller to datapath
	typedef struct packed {
		logic       item_load;
		logic       ring_shift;
		logic [1:0] byte_sel;
		logic       ring_restart;
		logic       ring_pad_restart;
		logic       ring_finish;
		logic       hash_step;
		logic [1:0] step;
		logic       lookup;
		logic       scan;
		logic       table_write;
		logic       score_clear;
		logic       out_load;
	} bqls_cmd_t;

	// datapath to controller
	typedef struct packed {
		bqls_op_t   op;
		logic       letter;
		logic [2:0] nbytes;
		logic       gram_ready;
		logic       out_busy;
	} bqls_status_t;

	function automatic logic [31:0] mix_step(input logic [31:0] h, input logic [31:0] v);
		return h ^ ((h << 5) + v + (h >> 2));
	endfunction

endpackage
`default_nettype wire

// ===== sv/bqls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bqls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/bqls_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_regs
// APB configuration registers: label count and table index mask.
// ----------------------------------------------------------------------------
module bqls_regs #(
	parameter int MAX_LABELS = bqls_pkg::MAX_LABELS_DEF,
	localparam int LBL_W     = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	output logic      [LBL_W-1:0] label_last,
	output logic      [15:0]      index_mask
);
	import bqls_pkg::*;

	logic [4:0]  label_count_q;
	logic [15:0] index_mask_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= 5'd1;
			index_mask_q  <= 16'hffff;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_LABEL_COUNT: label_count_q <= pwdata[4:0];
				REG_INDEX_MASK:  index_mask_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LABEL_COUNT: prdata = {27'd0, label_count_q};
			REG_INDEX_MASK:  prdata = {16'd0, index_mask_q};
			default:         prdata = '0;
		endcase
	end

	// zero acts as one label, anything past the build limit is clamped
	always_comb begin
		if (label_count_q == 5'd0) begin
			label_last = '0;
		end else if (int'(label_count_q) > MAX_LABELS) begin
			label_last = LBL_W'(MAX_LABELS - 1);
		end else begin
			label_last = LBL_W'(label_count_q - 5'd1);
		end
	end

	assign index_mask = index_mask_q;

endmodule
`default_nettype wire

// ===== sv/bqls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_ctrl
// Sequencer: byte shifts, hash steps, per-label table lookups and the
// best-label scan on finish.
// ----------------------------------------------------------------------------
module bqls_ctrl #(
	parameter int MAX_LABELS = bqls_pkg::MAX_LABELS_DEF,
	localparam int LBL_W     = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [LBL_W-1:0]       label_last,
	input  wire bqls_pkg::bqls_status_t status,
	output bqls_pkg::bqls_cmd_t         cmd,
	output logic      [LBL_W-1:0]       label
);
	import bqls_pkg::*;

	bqls_state_t      state_q, state_d;
	logic [1:0]       byte_idx_q, byte_idx_d;
	logic [1:0]       step_q, step_d;
	logic [LBL_W-1:0] lbl_q, lbl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			byte_idx_q <= '0;
			step_q     <= '0;
			lbl_q      <= '0;
		end else begin
			state_q    <= state_d;
			byte_idx_q <= byte_idx_d;
			step_q     <= step_d;
			lbl_q      <= lbl_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign label    = lbl_q;

	always_comb begin
		state_d      = state_q;
		byte_idx_d   = byte_idx_q;
		step_d       = step_q;
		lbl_d        = lbl_q;
		cmd          = '0;
		cmd.byte_sel = byte_idx_q;
		cmd.step     = step_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				byte_idx_d = '0;
				unique case (status.op)
					CMD_POINT: begin
						if (status.letter && status.nbytes == 3'd0) begin
							state_d = ST_IDLE;
						end else begin
							state_d = ST_SHIFT;
						end
					end
					CMD_FINISH: state_d = ST_SHIFT;
					CMD_LOAD: begin
						cmd.table_write = 1'b1;
						state_d         = ST_IDLE;
					end
					CMD_START: begin
						cmd.score_clear  = 1'b1;
						cmd.ring_restart = 1'b1;
						state_d          = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SHIFT, ST_DRAIN: begin
				if (state_q == ST_SHIFT) begin
					cmd.ring_shift = 1'b1;
				end
				if (state_q == ST_SHIFT && status.gram_ready) begin
					step_d  = '0;
					state_d = ST_HASH;
				end else if (status.op == CMD_FINISH) begin
					cmd.ring_finish = 1'b1;
					lbl_d           = '0;
					state_d         = ST_SCAN;
				end else if (status.letter) begin
					if ({1'b0, byte_idx_q} + 3'd1 < status.nbytes) begin
						byte_idx_d = byte_idx_q + 2'd1;
						state_d    = ST_SHIFT;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.ring_pad_restart = 1'b1;
					state_d              = ST_IDLE;
				end
			end
			ST_HASH: begin
				cmd.hash_step = 1'b1;
				step_d        = step_q + 2'd1;
				if (step_q == 2'd3) begin
					lbl_d   = '0;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (lbl_q == label_last) begin
					state_d = ST_DRAIN;
				end else begin
					lbl_d = lbl_q + 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (lbl_q == label_last) begin
					state_d = ST_SETTLE;
				end else begin
					lbl_d = lbl_q + 1'b1;
				end
			end
			ST_SETTLE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/bqls_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqls_dp
// Datapath: item register, byte ring, hash register, model table, label
// score registers, best-label tracking and the result register.
// ----------------------------------------------------------------------------
module bqls_dp #(
	parameter int TABLE_DEPTH = bqls_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_LABELS  = bqls_pkg::MAX_LABELS_DEF,
	localparam int LBL_W      = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1,
	localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [71:0]           in_data,
	input  wire logic [2:0]            in_user,
	input  wire logic [15:0]           index_mask,
	input  wire bqls_pkg::bqls_cmd_t   cmd,
	input  wire logic [LBL_W-1:0]      label,
	output bqls_pkg::bqls_status_t     status,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [55:0]           out_data
);
	import bqls_pkg::*;

	// item register
	bqls_op_t       op_q;
	logic           letter_q;
	logic [7:0]     bytes_q [GRAM_BYTES];
	logic [2:0]     nbytes_q;
	logic [15:0]    load_addr_q;
	logic [15:0]    load_val_q;

	// ring and hash
	logic [7:0]     ring_q [GRAM_BYTES];
	logic [1:0]     wp_q;
	logic [2:0]     fill_q;
	logic [31:0]    hash_q;
	logic [7:0]     shift_byte;
	logic [1:0]     hash_idx;
	logic [31:0]    hash_src;

	// table lookup
	logic [31:0]    mix_l;
	logic [31:0]    mask_ext;
	logic [31:0]    laddr_ext;
	logic [AW-1:0]  raddr;
	logic [WEIGHT_W-1:0] rdata;

	// scores
	logic [SCORE_W-1:0] scores_q [MAX_LABELS];
	logic               add_s1;
	logic               scan_s1;
	logic               first_s1;
	logic [LBL_W-1:0]   label_s1;
	logic [SCORE_W-1:0] score_rd;
	logic [SCORE_W:0]   sum;
	logic [SCORE_W-1:0] sum_sat;
	logic [SCORE_W-1:0] best_score_q;
	logic [LBL_W-1:0]   best_label_q;
	logic [31:0]        best_label_ext;

	// result register
	logic               out_valid_q;
	logic [3:0]         out_label_q;
	logic [SCORE_W-1:0] out_score_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q        <= bqls_op_t'(in_user[1:0]);
			letter_q    <= in_user[2];
			bytes_q[0]  <= in_data[7:0];
			bytes_q[1]  <= in_data[15:8];
			bytes_q[2]  <= in_data[23:16];
			bytes_q[3]  <= in_data[31:24];
			nbytes_q    <= (in_data[34:32] > 3'd4) ? 3'd4 : in_data[34:32];
			load_addr_q <= in_data[50:35];
			load_val_q  <= in_data[66:51];
		end
	end

	assign status.op         = op_q;
	assign status.letter     = letter_q;
	assign status.nbytes     = nbytes_q;
	assign status.gram_ready = (fill_q >= 3'd3);
	assign status.out_busy   = out_valid_q & ~out_ready;

	always_comb begin
		if (op_q != CMD_POINT || !letter_q) begin
			shift_byte = PAD_BYTE;
		end else begin
			shift_byte = bytes_q[cmd.byte_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRAM_BYTES; i++) begin
				ring_q[i] <= PAD_BYTE;
			end
			wp_q   <= 2'd1;
			fill_q <= 3'd1;
		end else begin
			// non-letter leaves just a pad in the first slot
			for (int i = 0; i < GRAM_BYTES; i++) begin
				if (cmd.ring_restart || (cmd.ring_pad_restart && i == 0)) begin
					ring_q[i] <= PAD_BYTE;
				end else if (cmd.ring_shift && wp_q == 2'(i)) begin
					ring_q[i] <= shift_byte;
				end
			end
			if (cmd.ring_restart || cmd.ring_pad_restart) begin
				wp_q   <= 2'd1;
				fill_q <= 3'd1;
			end else if (cmd.ring_finish) begin
				wp_q   <= 2'd0;
				fill_q <= 3'd0;
			end else if (cmd.ring_shift) begin
				wp_q <= wp_q + 2'd1;
				if (fill_q < 3'd4) begin
					fill_q <= fill_q + 3'd1;
				end
			end
		end
	end

	// oldest byte first, one mixing step per cycle
	assign hash_idx = wp_q + cmd.step;
	assign hash_src = (cmd.step == 2'd0) ? HASH_SEED : hash_q;

	always_ff @(posedge clk) begin
		if (cmd.hash_step) begin
			hash_q <= mix_step(hash_src, {24'd0, ring_q[hash_idx]});
		end
	end

	assign mix_l     = mix_step(hash_q, 32'(label));
	assign mask_ext  = 32'(index_mask);
	assign laddr_ext = 32'(load_addr_q);
	assign raddr     = mix_l[AW-1:0] & mask_ext[AW-1:0];

	bqls_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.table_write),
		.waddr (laddr_ext[AW-1:0]),
		.wdata (load_val_q),
		.re    (cmd.lookup),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1  <= 1'b0;
			scan_s1 <= 1'b0;
		end else begin
			add_s1  <= cmd.lookup;
			scan_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup || cmd.scan) begin
			label_s1 <= label;
			first_s1 <= (label == '0);
		end
	end

	assign score_rd = scores_q[label_s1];
	assign sum      = {1'b0, score_rd} + (SCORE_W + 1)'(rdata);
	assign sum_sat  = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LABELS; i++) begin
				scores_q[i] <= '0;
			end
		end else if (cmd.score_clear) begin
			for (int i = 0; i < MAX_LABELS; i++) begin
				scores_q[i] <= '0;
			end
		end else if (add_s1) begin
			scores_q[label_s1] <= sum_sat;
		end
	end

	// strict greater keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (first_s1 || score_rd > best_score_q) begin
				best_score_q <= score_rd;
				best_label_q <= label_s1;
			end
		end
	end

	assign best_label_ext = 32'(best_label_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_label_q <= best_label_ext[3:0];
			out_score_q <= best_score_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, out_score_q, out_label_q};

endmodule
`default_nettype wire

// ===== sv/byte_quadgram_language_scorer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_quadgram_language_scorer_core
// Language identification scorer over hashed byte quadgrams.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Load and start act in the decode state,
// and a code point shifts its bytes into the ring one by one. Each byte
// that completes a quadgram runs 4 hash mixing steps, then one model table
// read per label for n active labels through the single read port of the
// table RAM, and then the score update. Finish shifts in a padded byte,
// scores it when it completes a quadgram, then scans the scores, one label
// a cycle, and holds in its emit state while an earlier result still waits.
// The result register decouples the output side, so a new item is taken while
// a result waits. TABLE_DEPTH must be a power of two; the model table needs
// loading before use and has no clearing pass.
// ----------------------------------------------------------------------------
module byte_quadgram_language_scorer_core #(
	parameter int TABLE_DEPTH = bqls_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_LABELS  = bqls_pkg::MAX_LABELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// byte_first, byte_second, byte_third, byte_fourth, byte_count[2:0],
	// load_address[15:0], load_value[15:0], zero fill
	input  wire logic [71:0] s_tdata,
	// cmd[1:0], is_letter
	input  wire logic [2:0]  s_tuser,
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// best_label[3:0], best_score[47:0], zero fill
	output logic      [55:0] m_tdata
);
	import bqls_pkg::*;

	localparam int LBL_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

	logic [LBL_W-1:0] label_last;
	logic [15:0]      index_mask;
	logic [LBL_W-1:0] label;
	bqls_cmd_t        cmd;
	bqls_status_t     status;

	bqls_regs #(
		.MAX_LABELS (MAX_LABELS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.label_last (label_last),
		.index_mask (index_mask)
	);

	bqls_ctrl #(
		.MAX_LABELS (MAX_LABELS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.label_last (label_last),
		.status     (status),
		.cmd        (cmd),
		.label      (label)
	);

	bqls_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_LABELS  (MAX_LABELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata),
		.in_user    (s_tuser),
		.index_mask (index_mask),
		.cmd        (cmd),
		.label      (label),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule
`default_nettype wire

// ===== dv/quadgram_score_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadgram_score_checker
// Watches the register port and both streams of the quadgram scorer. It keeps
// its own copy of the ring, the scores and the model table, predicts the
// ranking for each finish and compares it with what the block emits.
// ----------------------------------------------------------------------------
module quadgram_score_checker
	import bqls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          mismatch_count,
	output int          results_due
);

	typedef struct packed {
		logic [3:0]  best_label;
		logic [47:0] best_score;
	} ranking_t;

	ranking_t    ranking_q[$];
	ranking_t    seen;
	logic [15:0] weight_table [TABLE_DEPTH_DEF];
	logic [7:0]  ring [GRAM_BYTES];
	logic [1:0]  wr_slot;
	logic [2:0]  ring_fill;
	logic [47:0] score [MAX_LABELS_DEF];
	logic [4:0]  label_count_reg;
	logic [15:0] index_mask_reg;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic [31:0] churn(input logic [31:0] h, input logic [31:0] v);
		return h ^ ((h << 5) + v + (h >> 2));
	endfunction

	// label count 0 scores one label, anything above the table scores all
	function automatic int unsigned labels_in_play();
		if (label_count_reg == 5'd0)
			return 1;
		if (label_count_reg > MAX_LABELS_DEF)
			return MAX_LABELS_DEF;
		return label_count_reg;
	endfunction

	function automatic void ring_reset();
		foreach (ring[i])
			ring[i] = PAD_BYTE;
		wr_slot = 2'd1;
		ring_fill = 3'd1;
	endfunction

	function automatic void accumulate_gram();
		logic [31:0]  h;
		logic [31:0]  hl;
		logic [15:0]  idx;
		logic [48:0]  sum;
		int unsigned  n;
		n = labels_in_play();
		h = HASH_SEED;
		// oldest byte sits at the write slot
		for (int i = 0; i < GRAM_BYTES; i++)
			h = churn(h, {24'd0, ring[2'(wr_slot + i)]});
		for (int l = 0; l < n; l++) begin
			hl = churn(h, l);
			idx = hl[15:0] & index_mask_reg;
			sum = {1'b0, score[l]} + weight_table[idx];
			score[l] = sum[48] ? '1 : sum[47:0];
		end
	endfunction

	function automatic void shift_in(input logic [7:0] b);
		ring[wr_slot] = b;
		wr_slot++;
		if (ring_fill < GRAM_BYTES)
			ring_fill++;
		if (ring_fill >= GRAM_BYTES)
			accumulate_gram();
	endfunction

	function automatic void apply_item(input logic [71:0] d, input logic [2:0] u);
		bqls_op_t    op;
		logic [2:0]  cnt;
		logic [3:0]  best;
		int unsigned n;
		ranking_t    r;
		op = bqls_op_t'(u[1:0]);
		case (op)
			CMD_POINT: begin
				if (u[2]) begin
					cnt = (d[34:32] > 3'd4) ? 3'd4 : d[34:32];
					for (int k = 0; k < cnt; k++)
						shift_in(d[8*k +: 8]);
				end else begin
					// word break: pad, then restart holding one pad
					shift_in(PAD_BYTE);
					ring[0] = PAD_BYTE;
					wr_slot = 2'd1;
					ring_fill = 3'd1;
				end
			end
			CMD_FINISH: begin
				shift_in(PAD_BYTE);
				wr_slot = 2'd0;
				ring_fill = 3'd0;
				n = labels_in_play();
				best = 4'd0;
				for (int i = 1; i < n; i++)
					if (score[i] > score[best])
						best = 4'(i);
				r.best_label = best;
				r.best_score = score[best];
				ranking_q.push_back(r);
			end
			CMD_LOAD: weight_table[d[50:35]] = d[66:51];
			CMD_START: begin
				foreach (score[i])
					score[i] = '0;
				ring_reset();
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_reset();
			foreach (score[i])
				score[i] = '0;
			label_count_reg = 5'd1;
			index_mask_reg = 16'hffff;
			ranking_q.delete();
			mismatch_count = 0;
			results_due = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_LABEL_COUNT)
						label_count_reg = pwdata[4:0];
					else
						index_mask_reg = pwdata[15:0];
				end else if (paddr[2] == REG_LABEL_COUNT) begin
					if (prdata != {27'd0, label_count_reg})
						report_mismatch("label_count read", prdata, label_count_reg);
				end else if (prdata != {16'd0, index_mask_reg}) begin
					report_mismatch("index_mask read", prdata, index_mask_reg);
				end
			end
			if (m_tvalid && m_tready) begin
				if (ranking_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 64'd0);
				end else begin
					seen = ranking_q.pop_front();
					if (m_tdata[3:0] != seen.best_label)
						report_mismatch("best_label", m_tdata[3:0], seen.best_label);
					if (m_tdata[51:4] != seen.best_score)
						report_mismatch("best_score", m_tdata[51:4], seen.best_score);
				end
			end
			if (s_tvalid && s_tready)
				apply_item(s_tdata, s_tuser);
			results_due = ranking_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the quadgram scorer: loads every model entry that the chosen masks
// can reach, runs a short directed text, then random texts under several
// label counts and masks, all but the last with random stalls on both
// streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import bqls_pkg::*;

	localparam int ITEMS_PER_PHASE = 215;
	localparam int LONG_HOLD       = 1000;
	localparam int SETTLE_CYCLES   = 150;

	typedef struct packed {
		bqls_op_t    op;
		logic        letter;
		logic [2:0]  cnt;
		logic [31:0] bytes;
		logic [15:0] addr;
		logic [15:0] val;
	} token_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	int          mismatch_count;
	int          results_due;

	bit          tx_gaps;
	bit          rx_gaps;
	bit          hold_req;
	int unsigned items_sent;

	byte_quadgram_language_scorer_core u_top (.*);

	quadgram_score_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random short stalls, one long hold on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic logic [15:0] random_weight();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 16'h3fff));
		endcase
	endfunction

	// unused fields carry junk so the block has to ignore them
	function automatic token_t junk_token(input bqls_op_t op);
		token_t t;
		t.op = op;
		t.letter = 1'($urandom);
		t.cnt = 3'($urandom);
		t.bytes = $urandom;
		t.addr = 16'($urandom);
		t.val = 16'($urandom);
		return t;
	endfunction

	task automatic send_token(input token_t t);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, t.val, t.addr, t.cnt, t.bytes};
		s_tuser <= {t.letter, t.op};
		items_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_point(input logic letter, input logic [2:0] cnt,
			input logic [31:0] bytes);
		token_t t;
		t = junk_token(CMD_POINT);
		t.letter = letter;
		t.cnt = cnt;
		t.bytes = bytes;
		send_token(t);
	endtask

	task automatic send_cmd(input bqls_op_t op);
		send_token(junk_token(op));
	endtask

	task automatic send_load(input logic [15:0] addr, input logic [15:0] val);
		token_t t;
		t = junk_token(CMD_LOAD);
		t.addr = addr;
		t.val = val;
		send_token(t);
	endtask

	// stop offering, let every ranking arrive, then give the block time to drain
	task automatic go_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_access(input bit write, input logic reg_idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {reg_idx, 2'b00};
		pwdata <= write ? data : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [4:0] labels, input logic [15:0] mask);
		go_quiet();
		reg_access(1'b1, REG_LABEL_COUNT, {27'd0, labels});
		reg_access(1'b1, REG_INDEX_MASK, {16'd0, mask});
		reg_access(1'b0, REG_LABEL_COUNT, 32'd0);
		reg_access(1'b0, REG_INDEX_MASK, 32'd0);
	endtask

	task automatic random_text(input int unsigned len);
		int unsigned pick;
		logic [31:0] bytes;
		if ($urandom_range(0, 4) != 0)
			send_cmd(CMD_START);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			bytes = $urandom;
			if (pick < 72) begin
				if ($urandom_range(0, 1) == 0)
					bytes[7:0] = 8'($urandom_range(8'h61, 8'h7a));
				send_point(1'b1, 3'($urandom_range(1, 4)), bytes);
			end else if (pick < 86) begin
				send_point(1'b0, 3'($urandom), bytes);
			end else if (pick < 92) begin
				// byte count outside 1..4
				send_point(1'b1, 3'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 7)), bytes);
			end else if (pick < 97) begin
				send_load(16'($urandom), random_weight());
			end else begin
				send_cmd(CMD_START);
			end
		end
		send_cmd(CMD_FINISH);
		if ($urandom_range(0, 5) == 0)
			send_cmd(CMD_FINISH);
	endtask

	task automatic run_phase(input logic [4:0] labels, input logic [15:0] mask, input bit squeeze);
		int unsigned target;
		set_config(labels, mask);
		target = items_sent + ITEMS_PER_PHASE;
		if (squeeze) begin
			// results pile up behind a long hold until the input stalls
			hold_req = 1'b1;
			repeat (5) random_text(2);
		end
		while (items_sent < target)
			random_text($urandom_range(4, 40));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// masks below stay within the low byte or the split mask 16'hc003,
		// so loading these entries keeps every lookup on a loaded one
		for (int a = 0; a < 256; a++)
			send_load(16'(a), random_weight());
		for (int hi = 1; hi < 4; hi++)
			for (int lo = 0; lo < 4; lo++)
				send_load({hi[1:0], 12'd0, lo[1:0]}, random_weight());

		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		set_config(5'd16, 16'h00ff);

		send_cmd(CMD_FINISH);
		send_cmd(CMD_START);
		send_point(1'b1, 3'd4, 32'h0000_0000);
		send_point(1'b1, 3'd4, 32'hffff_ffff);
		send_point(1'b1, 3'd1, 32'hdead_be68);
		send_point(1'b1, 3'd2, 32'h5a5a_a9c3);
		send_point(1'b1, 3'd3, 32'h11ad_b8e4);
		send_point(1'b1, 3'd0, 32'h6162_6364);
		send_point(1'b1, 3'd7, 32'h8098_9ff0);
		send_point(1'b1, 3'd5, 32'h7a79_7877);
		send_point(1'b1, 3'd6, 32'h0102_0304);
		send_point(1'b0, 3'd1, 32'h0000_0020);
		send_point(1'b0, 3'd4, 32'hc3c3_2e2c);
		send_point(1'b1, 3'd4, 32'h6c6c_6568);
		send_cmd(CMD_FINISH);
		send_cmd(CMD_FINISH);
		send_point(1'b1, 3'd4, 32'h646c_726f);
		send_cmd(CMD_FINISH);
		send_load(16'h0000, 16'hffff);
		send_load(16'hffff, 16'h0000);
		send_point(1'b1, 3'd4, 32'h7473_6574);
		send_cmd(CMD_START);
		send_cmd(CMD_FINISH);

		run_phase(5'd1, 16'h0000, 1'b1);
		run_phase(5'd0, 16'h00ff, 1'b0);
		run_phase(5'd31, 16'hc003, 1'b0);
		run_phase(5'd17, 16'h00f0, 1'b0);
		run_phase(5'd9, 16'h003f, 1'b0);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_phase(5'd16, 16'h00ff, 1'b0);

		go_quiet();
		if (mismatch_count == 0 && results_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
